// ----- hw/rtl/variable_partition_allocator_defines.svh -----
// Assertion macros used by the checker file of the partition allocator.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef VARIABLE_PARTITION_ALLOCATOR_DEFINES_SVH
`define VARIABLE_PARTITION_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VPA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vpa check failed");

// Next-cycle implication, checked outside reset.
`define VPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vpa check failed");

`endif

// ----- hw/rtl/vpa_pkg.sv -----
// Types and codes of the variable-partition allocator.
// Used by the top level and by its checker; depends on nothing.
package vpa_pkg;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RECLAIM = 1'b1;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_NOFIT = 2'd1,
    STAT_NOJOB = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [15:0] size;
  } fseg_t;

  typedef struct packed {
    logic [7:0]  job;
    logic [15:0] addr;
    logic [15:0] size;
  } aseg_t;

endpackage

// ----- hw/rtl/variable_partition_allocator.sv -----
// Variable-partition allocator: top level with the sequencer and both segment tables.
// Depends on vpa_pkg.
//
// The block manages a pool of KB-granular addresses with two address-ordered
// tables, one of free segments and one of allocated segments tagged by job id.
// An allocate item scans the free table by first, best or worst fit, carves the
// request off the low end of the chosen segment and inserts the new segment into
// the allocated table. A reclaim item finds the job's lowest-address segment,
// removes it and returns it to the free table, merging with the free neighbor
// below, above, both or neither. Every item yields exactly one result item.
// Each table is a memory with one write port and one registered read port, and
// one small sequencer walks them: every entry visited during a scan or a shift
// is read, then compared or written back. The block takes no new item until
// that work ends. A result waits in an output register, so the next item can be
// accepted while it is still stalled. After reset and after every configuration
// write the block, once idle, loads the whole pool as a single free segment
// (none if the clipped pool size is zero).
module variable_partition_allocator import vpa_pkg::*; #(
  parameter int MAX_JOBS = 16,
  parameter int MAX_FREE = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_job_id,
  input  logic [15:0] in_request_size,
  input  logic [1:0]  in_fit_policy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_seg_address,
  output logic [15:0] out_seg_size
);

  // Table index widths and count widths (a count can hold the depth itself).
  localparam int FA_W = $clog2(MAX_FREE);
  localparam int FC_W = $clog2(MAX_FREE + 1);
  localparam int JA_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int JC_W = $clog2(MAX_JOBS + 1);
  localparam int KW   = (FC_W > JC_W) ? FC_W : JC_W;

  typedef enum logic [3:0] {
    S_IDLE, S_ASCAN, S_APICK, S_ACARVE, S_FDN, S_APOS, S_AUP,
    S_RSCAN, S_RFPOS, S_RDEC, S_ADN, S_RMERGE, S_FUP, S_OUT
  } state_t;

  // Segment tables.
  fseg_t fmem [MAX_FREE];
  aseg_t amem [MAX_JOBS];
  fseg_t fq;
  aseg_t aq;

  logic [KW-1:0] fra, ara, fwa, awa;
  logic          fwe, awe;
  fseg_t         fwd;
  aseg_t         awd;

  // Control and working registers.
  state_t        state_r, state_nxt;
  logic          ph_r, ph_nxt;
  logic          init_r, init_nxt;
  logic [15:0]   pool_base_r, pool_base_nxt;
  logic [15:0]   pool_size_r, pool_size_nxt;
  logic [FC_W-1:0] fcnt_r, fcnt_nxt;
  logic [JC_W-1:0] acnt_r, acnt_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [KW-1:0] pick_r, pick_nxt;
  logic [KW-1:0] ai_r, ai_nxt;
  logic [KW-1:0] fi_r, fi_nxt;
  logic          found_r, found_nxt;
  logic [15:0]   best_r, best_nxt;
  logic          cmd_r, cmd_nxt;
  logic [7:0]    job_r, job_nxt;
  logic [15:0]   req_r, req_nxt;
  logic [1:0]    pol_r, pol_nxt;
  logic [15:0]   seg_addr_r, seg_addr_nxt;
  logic [15:0]   seg_size_r, seg_size_nxt;
  fseg_t         prev_r, prev_nxt;
  fseg_t         next_r, next_nxt;
  logic          below_r, below_nxt;
  logic          above_r, above_nxt;
  status_t       res_stat_r, res_stat_nxt;
  logic [15:0]   res_addr_r, res_addr_nxt;
  logic [15:0]   res_size_r, res_size_nxt;
  logic          out_valid_r, out_valid_nxt;
  status_t       out_stat_r, out_stat_nxt;
  logic [15:0]   out_addr_r, out_addr_nxt;
  logic [15:0]   out_size_r, out_size_nxt;

  // Finish request from the sequencer.
  logic          fin;
  status_t       fin_stat;
  logic [15:0]   fin_addr, fin_size;

  logic [16:0]   room;
  logic [15:0]   eff_size;
  logic [KW:0]   kp1;
  logic [KW-1:0] km1;
  logic [KW-1:0] fcnt_k, acnt_k;
  logic          below_c, above_c;

  // Pool size clipped so that base plus size stays within the address space.
  assign room     = 17'h10000 - {1'b0, pool_base_r};
  assign eff_size = ({1'b0, pool_size_r} < room) ? pool_size_r : room[15:0];

  assign kp1    = {1'b0, k_r} + 1'b1;
  assign km1    = k_r - 1'b1;
  assign fcnt_k = KW'(fcnt_r);
  assign acnt_k = KW'(acnt_r);

  assign below_c = (fi_r != '0) &&
                   (({1'b0, prev_r.addr} + {1'b0, prev_r.size}) == {1'b0, seg_addr_r});
  assign above_c = (fi_r < fcnt_k) &&
                   (({1'b0, seg_addr_r} + {1'b0, seg_size_r}) == {1'b0, next_r.addr});

  assign in_stall        = (state_r != S_IDLE) || init_r;
  assign out_valid       = out_valid_r;
  assign out_status      = out_stat_r;
  assign out_seg_address = out_addr_r;
  assign out_seg_size    = out_size_r;

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    init_nxt      = init_r;
    pool_base_nxt = pool_base_r;
    pool_size_nxt = pool_size_r;
    fcnt_nxt      = fcnt_r;
    acnt_nxt      = acnt_r;
    k_nxt         = k_r;
    pick_nxt      = pick_r;
    ai_nxt        = ai_r;
    fi_nxt        = fi_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    cmd_nxt       = cmd_r;
    job_nxt       = job_r;
    req_nxt       = req_r;
    pol_nxt       = pol_r;
    seg_addr_nxt  = seg_addr_r;
    seg_size_nxt  = seg_size_r;
    prev_nxt      = prev_r;
    next_nxt      = next_r;
    below_nxt     = below_r;
    above_nxt     = above_r;
    res_stat_nxt  = res_stat_r;
    res_addr_nxt  = res_addr_r;
    res_size_nxt  = res_size_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_stat_nxt  = out_stat_r;
    out_addr_nxt  = out_addr_r;
    out_size_nxt  = out_size_r;
    fra = k_r;
    ara = k_r;
    fwe = 1'b0;
    fwa = k_r;
    fwd = fq;
    awe = 1'b0;
    awa = k_r;
    awd = aq;
    fin = 1'b0;
    fin_stat = STAT_OK;
    fin_addr = '0;
    fin_size = '0;

    unique case (state_r)
      S_IDLE: begin
        if (init_r) begin
          fwe      = 1'b1;
          fwa      = '0;
          fwd      = '{addr: pool_base_r, size: eff_size};
          fcnt_nxt = (eff_size != '0) ? FC_W'(1) : '0;
          acnt_nxt = '0;
          init_nxt = 1'b0;
        end else if (in_valid) begin
          cmd_nxt = in_cmd;
          job_nxt = in_job_id;
          req_nxt = in_request_size;
          pol_nxt = in_fit_policy;
          k_nxt   = '0;
          ph_nxt  = 1'b0;
          found_nxt = 1'b0;
          if (in_cmd == CMD_ALLOC) begin
            if (acnt_r == JC_W'(MAX_JOBS)) begin
              fin = 1'b1;
              fin_stat = STAT_FULL;
            end else if (in_request_size == '0) begin
              fin = 1'b1;
              fin_stat = STAT_NOFIT;
            end else begin
              state_nxt = S_ASCAN;
            end
          end else begin
            state_nxt = S_RSCAN;
          end
        end
      end

      // Fit search over the free table.
      S_ASCAN: begin
        if (!ph_r) begin
          if (k_r >= fcnt_k) state_nxt = S_APICK;
          else ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          k_nxt  = kp1[KW-1:0];
          if (fq.size >= req_r) begin
            if (!found_r) begin
              found_nxt = 1'b1;
              pick_nxt  = k_r;
              best_nxt  = fq.size;
              if (pol_r != FIT_BEST && pol_r != FIT_WORST) state_nxt = S_APICK;
            end else if (pol_r == FIT_BEST && fq.size < best_r) begin
              pick_nxt = k_r;
              best_nxt = fq.size;
            end else if (pol_r == FIT_WORST && fq.size > best_r) begin
              pick_nxt = k_r;
              best_nxt = fq.size;
            end
          end
        end
      end

      S_APICK: begin
        fra = pick_r;
        if (!found_r) begin
          fin = 1'b1;
          fin_stat = STAT_NOFIT;
        end else begin
          state_nxt = S_ACARVE;
        end
      end

      // Carve the request off the low end of the chosen free segment.
      S_ACARVE: begin
        seg_addr_nxt = fq.addr;
        seg_size_nxt = req_r;
        ph_nxt       = 1'b0;
        if (fq.size > req_r) begin
          fwe       = 1'b1;
          fwa       = pick_r;
          fwd       = '{addr: fq.addr + req_r, size: fq.size - req_r};
          k_nxt     = '0;
          state_nxt = S_APOS;
        end else begin
          k_nxt     = pick_r;
          state_nxt = S_FDN;
        end
      end

      // Remove free entry k by moving the entries above it down one place.
      S_FDN: begin
        if (!ph_r) begin
          if (kp1 >= {1'b0, fcnt_k}) begin
            fcnt_nxt = fcnt_r - 1'b1;
            if (cmd_r == CMD_ALLOC) begin
              k_nxt     = '0;
              state_nxt = S_APOS;
            end else begin
              fin = 1'b1;
              fin_addr = seg_addr_r;
              fin_size = seg_size_r;
            end
          end else begin
            fra    = kp1[KW-1:0];
            ph_nxt = 1'b1;
          end
        end else begin
          fwe    = 1'b1;
          fwa    = k_r;
          fwd    = fq;
          k_nxt  = kp1[KW-1:0];
          ph_nxt = 1'b0;
        end
      end

      // Find the insertion place in the allocated table.
      S_APOS: begin
        if (!ph_r) begin
          if (k_r >= acnt_k) begin
            ai_nxt    = k_r;
            k_nxt     = acnt_k;
            state_nxt = S_AUP;
          end else begin
            ph_nxt = 1'b1;
          end
        end else begin
          ph_nxt = 1'b0;
          if (aq.addr < seg_addr_r) begin
            k_nxt = kp1[KW-1:0];
          end else begin
            ai_nxt    = k_r;
            k_nxt     = acnt_k;
            state_nxt = S_AUP;
          end
        end
      end

      // Open a hole at the insertion place and record the new segment.
      S_AUP: begin
        if (!ph_r) begin
          if (k_r == ai_r) begin
            awe      = 1'b1;
            awa      = ai_r;
            awd      = '{job: job_r, addr: seg_addr_r, size: seg_size_r};
            acnt_nxt = acnt_r + 1'b1;
            fin      = 1'b1;
            fin_addr = seg_addr_r;
            fin_size = seg_size_r;
          end else begin
            ara    = km1;
            ph_nxt = 1'b1;
          end
        end else begin
          awe    = 1'b1;
          awa    = k_r;
          awd    = aq;
          k_nxt  = km1;
          ph_nxt = 1'b0;
        end
      end

      // Find the job's lowest-address segment.
      S_RSCAN: begin
        if (!ph_r) begin
          if (k_r >= acnt_k) begin
            fin = 1'b1;
            fin_stat = STAT_NOJOB;
          end else begin
            ph_nxt = 1'b1;
          end
        end else begin
          ph_nxt = 1'b0;
          if (aq.job == job_r) begin
            ai_nxt       = k_r;
            seg_addr_nxt = aq.addr;
            seg_size_nxt = aq.size;
            k_nxt        = '0;
            state_nxt    = S_RFPOS;
          end else begin
            k_nxt = kp1[KW-1:0];
          end
        end
      end

      // Locate the free neighbors below and above the returned segment.
      S_RFPOS: begin
        if (!ph_r) begin
          if (k_r >= fcnt_k) begin
            fi_nxt    = k_r;
            state_nxt = S_RDEC;
          end else begin
            ph_nxt = 1'b1;
          end
        end else begin
          ph_nxt = 1'b0;
          if (fq.addr < seg_addr_r) begin
            prev_nxt = fq;
            k_nxt    = kp1[KW-1:0];
          end else begin
            next_nxt  = fq;
            fi_nxt    = k_r;
            state_nxt = S_RDEC;
          end
        end
      end

      S_RDEC: begin
        below_nxt = below_c;
        above_nxt = above_c;
        if (!below_c && !above_c && fcnt_r >= FC_W'(MAX_FREE)) begin
          fin = 1'b1;
          fin_stat = STAT_FULL;
        end else begin
          k_nxt     = ai_r;
          ph_nxt    = 1'b0;
          state_nxt = S_ADN;
        end
      end

      // Remove the allocated entry.
      S_ADN: begin
        if (!ph_r) begin
          if (kp1 >= {1'b0, acnt_k}) begin
            acnt_nxt  = acnt_r - 1'b1;
            state_nxt = S_RMERGE;
          end else begin
            ara    = kp1[KW-1:0];
            ph_nxt = 1'b1;
          end
        end else begin
          awe    = 1'b1;
          awa    = k_r;
          awd    = aq;
          k_nxt  = kp1[KW-1:0];
          ph_nxt = 1'b0;
        end
      end

      // The four coalescing cases.
      S_RMERGE: begin
        ph_nxt = 1'b0;
        if (below_r && above_r) begin
          fwe       = 1'b1;
          fwa       = fi_r - 1'b1;
          fwd       = '{addr: prev_r.addr, size: prev_r.size + seg_size_r + next_r.size};
          k_nxt     = fi_r;
          state_nxt = S_FDN;
        end else if (below_r) begin
          fwe      = 1'b1;
          fwa      = fi_r - 1'b1;
          fwd      = '{addr: prev_r.addr, size: prev_r.size + seg_size_r};
          fin      = 1'b1;
          fin_addr = seg_addr_r;
          fin_size = seg_size_r;
        end else if (above_r) begin
          fwe      = 1'b1;
          fwa      = fi_r;
          fwd      = '{addr: seg_addr_r, size: next_r.size + seg_size_r};
          fin      = 1'b1;
          fin_addr = seg_addr_r;
          fin_size = seg_size_r;
        end else begin
          k_nxt     = fcnt_k;
          state_nxt = S_FUP;
        end
      end

      // Open a hole in the free table and insert the segment on its own.
      S_FUP: begin
        if (!ph_r) begin
          if (k_r == fi_r) begin
            fwe      = 1'b1;
            fwa      = fi_r;
            fwd      = '{addr: seg_addr_r, size: seg_size_r};
            fcnt_nxt = fcnt_r + 1'b1;
            fin      = 1'b1;
            fin_addr = seg_addr_r;
            fin_size = seg_size_r;
          end else begin
            fra    = km1;
            ph_nxt = 1'b1;
          end
        end else begin
          fwe    = 1'b1;
          fwa    = k_r;
          fwd    = fq;
          k_nxt  = km1;
          ph_nxt = 1'b0;
        end
      end

      // Hand the result to the output register once it is free.
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_addr_nxt  = res_addr_r;
          out_size_nxt  = res_size_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (fin) begin
      res_stat_nxt = fin_stat;
      res_addr_nxt = fin_addr;
      res_size_nxt = fin_size;
      state_nxt    = S_OUT;
    end

    // A configuration write reloads the pool.
    if (cfg_write_en) begin
      init_nxt = 1'b1;
      if (cfg_index) pool_size_nxt = cfg_wdata;
      else pool_base_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= 1'b0;
      init_r      <= 1'b1;
      pool_base_r <= 16'd0;
      pool_size_r <= 16'd1024;
      fcnt_r      <= '0;
      acnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      init_r      <= init_nxt;
      pool_base_r <= pool_base_nxt;
      pool_size_r <= pool_size_nxt;
      fcnt_r      <= fcnt_nxt;
      acnt_r      <= acnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r        <= k_nxt;
    pick_r     <= pick_nxt;
    ai_r       <= ai_nxt;
    fi_r       <= fi_nxt;
    found_r    <= found_nxt;
    best_r     <= best_nxt;
    cmd_r      <= cmd_nxt;
    job_r      <= job_nxt;
    req_r      <= req_nxt;
    pol_r      <= pol_nxt;
    seg_addr_r <= seg_addr_nxt;
    seg_size_r <= seg_size_nxt;
    prev_r     <= prev_nxt;
    next_r     <= next_nxt;
    below_r    <= below_nxt;
    above_r    <= above_nxt;
    res_stat_r <= res_stat_nxt;
    res_addr_r <= res_addr_nxt;
    res_size_r <= res_size_nxt;
    out_stat_r <= out_stat_nxt;
    out_addr_r <= out_addr_nxt;
    out_size_r <= out_size_nxt;
  end

  // Table memories: one write and one registered read each per cycle.
  always_ff @(posedge clk) begin
    if (fwe) fmem[fwa[FA_W-1:0]] <= fwd;
    fq <= fmem[fra[FA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (awe) amem[awa[JA_W-1:0]] <= awd;
    aq <= amem[ara[JA_W-1:0]];
  end

endmodule

// ----- hw/rtl/vpa_checker.sv -----
// Port-level checks for the variable-partition allocator, bound to its top level.
// Depends on vpa_pkg and variable_partition_allocator_defines.svh.
`include "variable_partition_allocator_defines.svh"

module vpa_checker import vpa_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [15:0] out_seg_address,
  input logic [15:0] out_seg_size
);

  // A stalled result stays offered.
  `VPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  // An accepted item keeps the block busy in the next cycle.
  `VPA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // A failed command reports an empty segment.
  `VPA_ASSERT_NOW(a_fail_zero, out_valid && out_status != STAT_OK,
                  out_seg_address == 16'd0 && out_seg_size == 16'd0)

endmodule

bind variable_partition_allocator vpa_checker u_vpa_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the variable-partition allocator.
// Depends on vpa_pkg and variable_partition_allocator; drives items, predicts results.
module tb;
  import vpa_pkg::*;

  localparam int NUM_JOBS = 16;
  localparam int NUM_FREE = 32;
  // Generous wait after the last item.
  localparam int DRAIN_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    logic        cmd;
    logic [7:0]  job;
    logic [15:0] req;
    logic [1:0]  pol;
  } cmd_item_t;

  typedef struct {
    status_t     status;
    logic [15:0] addr;
    logic [15:0] size;
  } seg_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_write_en = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = 1'b0;
  logic [7:0]  in_job_id = '0;
  logic [15:0] in_request_size = '0;
  logic [1:0]  in_fit_policy = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [15:0] out_seg_address;
  logic [15:0] out_seg_size;

  variable_partition_allocator #(.MAX_JOBS(NUM_JOBS), .MAX_FREE(NUM_FREE)) i_dut (
    .clk, .rst_n, .cfg_write_en, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_cmd, .in_job_id, .in_request_size, .in_fit_policy,
    .out_valid, .out_stall, .out_status, .out_seg_address, .out_seg_size
  );

  always #5 clk = ~clk;

  // Predictor state: its own copy of both segment tables and the pool registers.
  // Addresses are kept 17 bits wide so that the end of a clipped pool (65536) fits.
  logic [16:0] free_addr [NUM_FREE];
  logic [16:0] free_size [NUM_FREE];
  int          free_used;
  logic [7:0]  job_tag   [NUM_JOBS];
  logic [16:0] job_addr  [NUM_JOBS];
  logic [16:0] job_size  [NUM_JOBS];
  int          job_used;
  logic [15:0] pool_base_q = 16'd0;
  logic [15:0] pool_size_q = 16'd1024;

  cmd_item_t   pending_cmds[$];
  seg_result_t expected_segs[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          recv_hold = 1'b0;

  // A configuration write wipes the pool back to one free segment, or none for a zero size.
  function automatic void reload_pool();
    logic [16:0] room;
    logic [16:0] sz;
    room = 17'h10000 - {1'b0, pool_base_q};
    sz = ({1'b0, pool_size_q} < room) ? {1'b0, pool_size_q} : room;
    job_used = 0;
    free_used = 0;
    if (sz != 0) begin
      free_addr[0] = {1'b0, pool_base_q};
      free_size[0] = sz;
      free_used = 1;
    end
  endfunction

  function automatic seg_result_t carve_segment(logic [7:0] job, logic [15:0] req,
                                                logic [1:0] pol);
    seg_result_t r;
    int pick;
    bit found;
    logic [16:0] a;
    int pos;
    r = '{STAT_OK, 16'd0, 16'd0};
    pick = 0;
    found = 1'b0;
    if (job_used >= NUM_JOBS) begin
      r.status = STAT_FULL;
      return r;
    end
    if (req == 0) begin
      r.status = STAT_NOFIT;
      return r;
    end
    for (int i = 0; i < free_used; i++) begin
      if (free_size[i] < req) continue;
      if (!found) begin
        pick = i;
        found = 1'b1;
        if (pol != FIT_BEST && pol != FIT_WORST) break;
      end else if (pol == FIT_BEST && free_size[i] < free_size[pick]) begin
        pick = i;
      end else if (pol == FIT_WORST && free_size[i] > free_size[pick]) begin
        pick = i;
      end
    end
    if (!found) begin
      r.status = STAT_NOFIT;
      return r;
    end
    a = free_addr[pick];
    if (free_size[pick] > req) begin
      free_addr[pick] += req;
      free_size[pick] -= req;
    end else begin
      for (int k = pick; k + 1 < free_used; k++) begin
        free_addr[k] = free_addr[k+1];
        free_size[k] = free_size[k+1];
      end
      free_used--;
    end
    pos = 0;
    while (pos < job_used && job_addr[pos] < a) pos++;
    for (int k = job_used; k > pos; k--) begin
      job_tag[k] = job_tag[k-1];
      job_addr[k] = job_addr[k-1];
      job_size[k] = job_size[k-1];
    end
    job_tag[pos] = job;
    job_addr[pos] = a;
    job_size[pos] = {1'b0, req};
    job_used++;
    r.addr = a[15:0];
    r.size = req;
    return r;
  endfunction

  function automatic seg_result_t return_segment(logic [7:0] job);
    seg_result_t r;
    int ai;
    int fi;
    logic [16:0] a;
    logic [16:0] s;
    bit below;
    bit above;
    r = '{STAT_OK, 16'd0, 16'd0};
    ai = 0;
    while (ai < job_used && job_tag[ai] != job) ai++;
    if (ai >= job_used) begin
      r.status = STAT_NOJOB;
      return r;
    end
    a = job_addr[ai];
    s = job_size[ai];
    fi = 0;
    while (fi < free_used && free_addr[fi] < a) fi++;
    below = (fi > 0) && (free_addr[fi-1] + free_size[fi-1] == a);
    above = (fi < free_used) && (a + s == free_addr[fi]);
    if (!below && !above && free_used >= NUM_FREE) begin
      r.status = STAT_FULL;
      return r;
    end
    for (int k = ai; k + 1 < job_used; k++) begin
      job_tag[k] = job_tag[k+1];
      job_addr[k] = job_addr[k+1];
      job_size[k] = job_size[k+1];
    end
    job_used--;
    if (below && above) begin
      free_size[fi-1] += s + free_size[fi];
      for (int k = fi; k + 1 < free_used; k++) begin
        free_addr[k] = free_addr[k+1];
        free_size[k] = free_size[k+1];
      end
      free_used--;
    end else if (below) begin
      free_size[fi-1] += s;
    end else if (above) begin
      free_addr[fi] = a;
      free_size[fi] += s;
    end else begin
      for (int k = free_used; k > fi; k--) begin
        free_addr[k] = free_addr[k-1];
        free_size[k] = free_size[k-1];
      end
      free_addr[fi] = a;
      free_size[fi] = s;
      free_used++;
    end
    r.addr = a[15:0];
    r.size = s[15:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("MISMATCH %s: got %0d, expected %0d at cycle %0d", what, got, want, cycle_count);
    fail_count++;
  endtask

  // Driver: holds an item until it is accepted, then takes the next one or idles.
  // The prediction is made at acceptance, so the expectation order follows the block's.
  always @(posedge clk) begin
    cmd_item_t c;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (in_cmd == CMD_ALLOC)
          expected_segs.push_back(carve_segment(in_job_id, in_request_size, in_fit_policy));
        else
          expected_segs.push_back(return_segment(in_job_id));
      end
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          c = pending_cmds.pop_front();
          in_valid <= 1'b1;
          in_cmd <= c.cmd;
          in_job_id <= c.job;
          in_request_size <= c.req;
          in_fit_policy <= c.pol;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    seg_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_segs.size() == 0) begin
        $display("UNEXPECTED result item at cycle %0d", cycle_count);
        fail_count++;
      end else begin
        e = expected_segs.pop_front();
        if (out_status !== e.status) report_mismatch("status", {14'd0, out_status}, {14'd0, e.status});
        if (out_seg_address !== e.addr) report_mismatch("seg_address", out_seg_address, e.addr);
        if (out_seg_size !== e.size) report_mismatch("seg_size", out_seg_size, e.size);
      end
    end
    if (rst_n) out_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic queue_cmd(input logic cmd, input logic [7:0] job, input logic [15:0] req,
                           input logic [1:0] pol);
    pending_cmds.push_back('{cmd, job, req, pol});
  endtask

  // Waits until the block has taken every item and returned every result.
  // The check runs just after the edge, once the driver and monitor have settled.
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_cmds.size() > 0 || in_valid || expected_segs.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (idx == 1'b0) pool_base_q = val;
    else pool_size_q = val;
    reload_pool();
    @(posedge clk);
  endtask

  // Random traffic: mostly allocations of small sizes with recycled job ids, so
  // the tables fill, fragment and merge; a few huge and zero requests; any policy, 3 included.
  task automatic queue_random(input int n, input int pool_kb);
    logic [15:0] req;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0:       req = 16'($urandom_range(65535));
        1:       req = 16'd0;
        2, 3:    req = 16'($urandom_range(pool_kb));
        default: req = 16'($urandom_range(1, pool_kb / 8 + 1));
      endcase
      queue_cmd($urandom_range(99) < 45 ? CMD_RECLAIM : CMD_ALLOC,
                $urandom_range(99) < 97 ? 8'($urandom_range(23)) : 8'($urandom_range(255)),
                req, 2'($urandom_range(3)));
    end
  endtask

  initial begin
    reload_pool();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on the reset pool of 1024 KB at base 0.
    queue_cmd(CMD_RECLAIM, 8'd5, 16'd0, FIT_FIRST);     // reclaim of an unknown job
    queue_cmd(CMD_ALLOC, 8'd1, 16'd0, FIT_FIRST);       // zero request
    queue_cmd(CMD_ALLOC, 8'd1, 16'hFFFF, FIT_WORST);    // larger than the pool
    queue_cmd(CMD_ALLOC, 8'd1, 16'd100, FIT_FIRST);
    queue_cmd(CMD_ALLOC, 8'd2, 16'd50, FIT_BEST);
    queue_cmd(CMD_ALLOC, 8'd3, 16'd200, FIT_WORST);
    queue_cmd(CMD_ALLOC, 8'd4, 16'd50, 2'd3);           // unused policy acts as first fit
    queue_cmd(CMD_ALLOC, 8'd1, 16'd50, FIT_FIRST);      // duplicate job id
    queue_cmd(CMD_RECLAIM, 8'd2, 16'hFFFF, FIT_WORST);  // no free neighbor
    queue_cmd(CMD_RECLAIM, 8'd4, 16'd0, FIT_FIRST);     // free neighbor above is none, below none
    queue_cmd(CMD_ALLOC, 8'd6, 16'd50, FIT_BEST);       // tie between equal holes
    queue_cmd(CMD_RECLAIM, 8'd1, 16'd0, FIT_FIRST);     // lowest of duplicate ids
    queue_cmd(CMD_RECLAIM, 8'd6, 16'd0, FIT_FIRST);     // merge below
    queue_cmd(CMD_RECLAIM, 8'd3, 16'd0, FIT_FIRST);     // merge with both sides
    queue_cmd(CMD_RECLAIM, 8'd1, 16'd0, FIT_FIRST);     // merge, back to one segment
    queue_cmd(CMD_ALLOC, 8'd255, 16'd1024, FIT_WORST);  // exact fit removes the free entry
    queue_cmd(CMD_ALLOC, 8'd0, 16'd1, FIT_FIRST);       // nothing free left
    queue_cmd(CMD_RECLAIM, 8'd255, 16'd0, FIT_BEST);
    for (int j = 0; j < NUM_JOBS + 1; j++)              // the last one finds the table full
      queue_cmd(CMD_ALLOC, 8'(j), 16'd1, FIT_FIRST);
    wait_idle();

    // Fill the job table, then free every other segment to leave isolated holes.
    write_reg(1'b1, 16'd64);
    for (int j = 0; j < NUM_JOBS; j++) queue_cmd(CMD_ALLOC, 8'(j), 16'd2, FIT_FIRST);
    for (int j = 0; j < NUM_JOBS; j += 2) queue_cmd(CMD_RECLAIM, 8'(j), 16'd0, FIT_FIRST);
    wait_idle();

    // Zero pool, then the pool clipped at the top of the address space.
    write_reg(1'b1, 16'd0);
    queue_cmd(CMD_ALLOC, 8'd7, 16'd1, FIT_FIRST);
    wait_idle();
    write_reg(1'b0, 16'hFFFF);
    write_reg(1'b1, 16'hFFFF);
    queue_cmd(CMD_ALLOC, 8'd7, 16'd2, FIT_FIRST);
    queue_cmd(CMD_ALLOC, 8'd8, 16'd1, FIT_FIRST);
    queue_cmd(CMD_RECLAIM, 8'd8, 16'd0, FIT_FIRST);
    wait_idle();

    // Random phases: sender mostly busy and receiver mostly stalled, then the reverse,
    // then no idling. A long receiver hold-off fills the output register.
    write_reg(1'b0, 16'd0);
    write_reg(1'b1, 16'd1024);
    send_idle_pct = 15;
    recv_idle_pct = 83;
    queue_random(230, 1024);
    wait_idle();

    write_reg(1'b0, 16'd4096);
    write_reg(1'b1, 16'd256);
    send_idle_pct = 83;
    recv_idle_pct = 15;
    queue_random(230, 256);
    wait_idle();

    write_reg(1'b0, 16'd0);
    write_reg(1'b1, 16'hFFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 1'b1;
    queue_random(240, 4096);
    repeat (600) @(posedge clk);
    recv_hold = 1'b0;
    wait_idle();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/vpa_pkg.sv
hw/rtl/variable_partition_allocator.sv
hw/rtl/vpa_checker.sv
tb/tb.sv
